[rtl/source_char_tokenizer_macros.svh]
// Assertion macros used by the tokenizer RTL.
`ifndef SOURCE_CHAR_TOKENIZER_MACROS_SVH
`define SOURCE_CHAR_TOKENIZER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SCT_ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define SCT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define SCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/sct_pkg.sv]
// Package for the source character tokenizer: types, codes and keyword table.
package sct_pkg;

  localparam int MAX_KEYWORD_CHARS_DEF = 7;
  localparam int IDENT_INDEX_BITS_DEF  = 16;
  localparam int STRING_INDEX_BITS_DEF = 16;

  typedef enum logic [3:0] {
    MODE_IDLE     = 4'd0,
    MODE_WORD     = 4'd1,
    MODE_NUM      = 4'd2,
    MODE_SLASH    = 4'd3,
    MODE_CMT      = 4'd4,
    MODE_CMT_STAR = 4'd5,
    MODE_CMP      = 4'd6,
    MODE_BANG     = 4'd7,
    MODE_STR      = 4'd8
  } mode_t;

  typedef enum logic [1:0] {
    CMP_EQ = 2'd0,
    CMP_LT = 2'd1,
    CMP_GT = 2'd2
  } cmp_t;

  // Token kinds
  localparam logic [5:0] KIND_ERROR   = 6'd0;
  localparam logic [5:0] KIND_ID      = 6'd16;
  localparam logic [5:0] KIND_MUL     = 6'd18;
  localparam logic [5:0] KIND_DIV     = 6'd19;
  localparam logic [5:0] KIND_MOD     = 6'd20;
  localparam logic [5:0] KIND_PLUS    = 6'd21;
  localparam logic [5:0] KIND_MINUS   = 6'd22;
  localparam logic [5:0] KIND_LT      = 6'd23;
  localparam logic [5:0] KIND_GT      = 6'd24;
  localparam logic [5:0] KIND_LE      = 6'd25;
  localparam logic [5:0] KIND_GE      = 6'd26;
  localparam logic [5:0] KIND_EQ      = 6'd27;
  localparam logic [5:0] KIND_NE      = 6'd28;
  localparam logic [5:0] KIND_ASSIGN  = 6'd31;
  localparam logic [5:0] KIND_LBRACE  = 6'd32;
  localparam logic [5:0] KIND_RBRACE  = 6'd33;
  localparam logic [5:0] KIND_SEMI    = 6'd34;
  localparam logic [5:0] KIND_COMMA   = 6'd35;
  localparam logic [5:0] KIND_COLON   = 6'd36;
  localparam logic [5:0] KIND_LPAREN  = 6'd37;
  localparam logic [5:0] KIND_RPAREN  = 6'd38;
  localparam logic [5:0] KIND_COMMENT = 6'd39;
  localparam logic [5:0] KIND_NUMBER  = 6'd40;
  localparam logic [5:0] KIND_STRING  = 6'd41;
  localparam logic [5:0] KIND_END     = 6'd42;

  // Error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_OPEN_COMMENT = 3'd1;
  localparam logic [2:0] ERR_LONE_BANG    = 3'd2;
  localparam logic [2:0] ERR_BAD_CHAR     = 3'd3;
  localparam logic [2:0] ERR_OPEN_STRING  = 3'd4;

  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

  // Characters
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;

  // Keyword table; each text is right-aligned, first character most significant.
  localparam int KW_COUNT = 19;
  localparam int KW_CHARS = 7;

  localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
    "program", "if", "else", "while", "for", "step", "until", "do", "goto",
    "read", "write", "true", "false", "int", "string", "boolean", "not",
    "and", "or"
  };

  localparam int KW_LEN [KW_COUNT] = '{
    7, 2, 4, 5, 3, 4, 5, 2, 4, 4, 5, 4, 5, 3, 6, 7, 3, 3, 2
  };

  localparam logic [5:0] KW_KIND [KW_COUNT] = '{
    6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10,
    6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd17, 6'd29, 6'd30
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [30:0] value;
    logic [2:0]  err;
    logic        last;
  } token_t;

  // Character i of keyword k, or zero beyond its length.
  function automatic logic [7:0] kw_byte(input int k, input int i);
    logic [8*KW_CHARS-1:0] text;
    text = KW_TEXT[k];
    if (i < KW_LEN[k]) begin
      return text[8*(KW_LEN[k]-1-i) +: 8];
    end else begin
      return 8'd0;
    end
  endfunction

  // Kind of a one-character delimiter, or zero when the character is none.
  function automatic logic [5:0] delim_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      8'h2A:   k = KIND_MUL;
      8'h25:   k = KIND_MOD;
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h3B:   k = KIND_SEMI;
      8'h2C:   k = KIND_COMMA;
      8'h3A:   k = KIND_COLON;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

[rtl/source_char_tokenizer.sv]
// Source character tokenizer: scans characters into tokens in a single registered pass.
//
// The input channel (in_valid, in_stall, op, ch) carries one source character per
// request, or an end-of-input mark when op is high. The output channel (out_valid,
// out_stall, token_kind, token_value, error_code, last) carries one token per request;
// last marks the final token caused by an input request.
// A character that closes a pending word, number, slash or comparison is scanned again
// in the same cycle, so one input request can produce two tokens.
// Each request is decoded in the cycle it is accepted and its tokens are written into a
// four-entry result queue; the output channel is driven from the queue's head entry.
// Throughput is one input request per cycle while each request yields at most one
// token and no stall holds the flow; a request yielding two tokens sends both in turn.
// The figure is set by the single output port draining the result queue.
// in_stall rises once the queue holds more than two tokens, so a stalled receiver
// backs up into the input after at most three further requests that yield tokens.
// Reset clears the scanner state, the ordinal counters and the queue. After an end mark
// every further request yields one end-of-program token until the next reset.
`include "source_char_tokenizer_macros.svh"

module source_char_tokenizer
  import sct_pkg::*;
#(
  parameter int MAX_KEYWORD_CHARS = MAX_KEYWORD_CHARS_DEF,
  parameter int IDENT_INDEX_BITS  = IDENT_INDEX_BITS_DEF,
  parameter int STRING_INDEX_BITS = STRING_INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  token_kind,
  output logic [30:0] token_value,
  output logic [2:0]  error_code,
  output logic        last
);

  localparam int NAME_LEN_W = $clog2(MAX_KEYWORD_CHARS + 2);
  localparam int NAME_IDX_W = $clog2(MAX_KEYWORD_CHARS);
  localparam logic [NAME_LEN_W-1:0] NAME_KEEP = NAME_LEN_W'(MAX_KEYWORD_CHARS);

  // Scanner state
  mode_t                        mode, mode_next;
  logic [7:0]                   name_chars [MAX_KEYWORD_CHARS];
  logic [NAME_LEN_W-1:0]        name_length, name_length_next;
  logic [30:0]                  number_accum, number_accum_next;
  logic [IDENT_INDEX_BITS-1:0]  ident_count, ident_count_next;
  logic [STRING_INDEX_BITS-1:0] string_count, string_count_next;
  cmp_t                         compare_first, compare_first_next;
  logic                         input_ended, input_ended_next;

  logic                  name_wr;
  logic [NAME_IDX_W-1:0] name_wr_idx;

  // Result queue
  token_t     fifo [4];
  logic [1:0] head, tail;
  logic [2:0] count;

  logic       accept, pop;
  logic [1:0] push_n;
  token_t     res0, res1;

  // Character classes
  logic       is_letter, is_digit, is_blank, is_alnum;
  logic [3:0] digit;
  logic [5:0] dkind;

  assign accept    = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign is_letter = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_alnum  = is_letter || is_digit;
  assign is_blank  = (ch == CH_SPACE) || (ch == CH_LF) || (ch == CH_CR) || (ch == CH_TAB);
  assign digit     = 4'(ch - CH_ZERO);
  assign dkind     = delim_kind(ch);

  // What the idle state makes of the current request.
  mode_t      idle_mode;
  logic       idle_emit, idle_ended;
  logic [5:0] idle_kind;
  logic [2:0] idle_err;
  cmp_t       idle_cmp;

  always_comb begin
    idle_mode  = MODE_IDLE;
    idle_emit  = 1'b0;
    idle_ended = 1'b0;
    idle_kind  = KIND_ERROR;
    idle_err   = ERR_NONE;
    idle_cmp   = CMP_EQ;
    if (op) begin
      idle_emit  = 1'b1;
      idle_kind  = KIND_END;
      idle_ended = 1'b1;
    end else if (is_blank) begin
      idle_mode = MODE_IDLE;
    end else if (is_letter) begin
      idle_mode = MODE_WORD;
    end else if (is_digit) begin
      idle_mode = MODE_NUM;
    end else if (ch == CH_SLASH) begin
      idle_mode = MODE_SLASH;
    end else if (ch == CH_EQ || ch == CH_LT || ch == CH_GT) begin
      idle_mode = MODE_CMP;
      idle_cmp  = (ch == CH_EQ) ? CMP_EQ : (ch == CH_LT) ? CMP_LT : CMP_GT;
    end else if (ch == CH_BANG) begin
      idle_mode = MODE_BANG;
    end else if (ch == CH_QUOTE) begin
      idle_mode = MODE_STR;
    end else if (dkind != KIND_ERROR) begin
      idle_emit = 1'b1;
      idle_kind = dkind;
    end else begin
      idle_emit = 1'b1;
      idle_err  = ERR_BAD_CHAR;
    end
  end

  // Keyword match against the stored word; entries at or above name_length are never
  // compared, because the length test fails first.
  logic [5:0] word_kind;

  always_comb begin
    logic hit;
    word_kind = KIND_ID;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      hit = (name_length == NAME_LEN_W'(KW_LEN[k]));
      for (int i = 0; i < KW_CHARS; i++) begin
        if (i < KW_LEN[k]) begin
          hit = hit && (name_chars[i] == kw_byte(k, i));
        end
      end
      if (hit) begin
        word_kind = KW_KIND[k];
      end
    end
  end

  // Decimal accumulate by shift and add, saturating at the largest 31-bit value.
  logic [34:0] num_wide;
  logic [30:0] num_step;

  assign num_wide = ({4'd0, number_accum} << 3) + ({4'd0, number_accum} << 1) + 35'(digit);
  assign num_step = (num_wide > 35'(NUM_MAX)) ? NUM_MAX : num_wide[30:0];

  // Next scan mode, and whether the character is scanned again from idle.
  logic  again, use_idle;
  mode_t pass_mode;

  always_comb begin
    again     = 1'b0;
    pass_mode = MODE_IDLE;
    case (mode)
      MODE_IDLE: begin
        pass_mode = MODE_IDLE;
      end
      MODE_WORD: begin
        if (!op && is_alnum) begin
          pass_mode = MODE_WORD;
        end else begin
          again = 1'b1;
        end
      end
      MODE_NUM: begin
        if (!op && is_digit) begin
          pass_mode = MODE_NUM;
        end else begin
          again = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (!op && ch == CH_STAR) begin
          pass_mode = MODE_CMT;
        end else begin
          again = 1'b1;
        end
      end
      MODE_CMT, MODE_CMT_STAR: begin
        if (op) begin
          pass_mode = MODE_IDLE;
        end else if (mode == MODE_CMT_STAR && ch == CH_SLASH) begin
          pass_mode = MODE_IDLE;
        end else begin
          pass_mode = (ch == CH_STAR) ? MODE_CMT_STAR : MODE_CMT;
        end
      end
      MODE_CMP: begin
        if (op || ch != CH_EQ) begin
          again = 1'b1;
        end
      end
      MODE_BANG: begin
        pass_mode = MODE_IDLE;
      end
      MODE_STR: begin
        pass_mode = (op || ch == CH_QUOTE) ? MODE_IDLE : MODE_STR;
      end
      default: begin
        again = 1'b1;
      end
    endcase
    use_idle = (mode == MODE_IDLE) || again;
    if (input_ended) begin
      mode_next = mode;
    end else begin
      mode_next = use_idle ? idle_mode : pass_mode;
    end
  end

  // Tokens produced by the request.
  always_comb begin
    logic        pass_emit;
    logic [5:0]  pass_kind;
    logic [30:0] pass_value;
    logic [2:0]  pass_err;
    pass_emit  = 1'b0;
    pass_kind  = KIND_ERROR;
    pass_value = '0;
    pass_err   = ERR_NONE;
    case (mode)
      MODE_WORD: begin
        if (op || !is_alnum) begin
          pass_emit = 1'b1;
          pass_kind = word_kind;
          if (word_kind == KIND_ID) begin
            pass_value = 31'(ident_count);
          end
        end
      end
      MODE_NUM: begin
        if (op || !is_digit) begin
          pass_emit  = 1'b1;
          pass_kind  = KIND_NUMBER;
          pass_value = number_accum;
        end
      end
      MODE_SLASH: begin
        if (op || ch != CH_STAR) begin
          pass_emit = 1'b1;
          pass_kind = KIND_DIV;
        end
      end
      MODE_CMT, MODE_CMT_STAR: begin
        if (op) begin
          pass_emit = 1'b1;
          pass_err  = ERR_OPEN_COMMENT;
        end else if (mode == MODE_CMT_STAR && ch == CH_SLASH) begin
          pass_emit = 1'b1;
          pass_kind = KIND_COMMENT;
        end
      end
      MODE_CMP: begin
        pass_emit = 1'b1;
        if (!op && ch == CH_EQ) begin
          case (compare_first)
            CMP_EQ:  pass_kind = KIND_EQ;
            CMP_LT:  pass_kind = KIND_LE;
            default: pass_kind = KIND_GE;
          endcase
        end else begin
          case (compare_first)
            CMP_EQ:  pass_kind = KIND_ASSIGN;
            CMP_LT:  pass_kind = KIND_LT;
            default: pass_kind = KIND_GT;
          endcase
        end
      end
      MODE_BANG: begin
        pass_emit = 1'b1;
        if (!op && ch == CH_EQ) begin
          pass_kind = KIND_NE;
        end else begin
          pass_err = ERR_LONE_BANG;
        end
      end
      MODE_STR: begin
        if (op) begin
          pass_emit = 1'b1;
          pass_err  = ERR_OPEN_STRING;
        end else if (ch == CH_QUOTE) begin
          pass_emit  = 1'b1;
          pass_kind  = KIND_STRING;
          pass_value = 31'(string_count);
        end
      end
      default: begin
        pass_emit = 1'b0;
      end
    endcase

    res0   = '{kind: idle_kind, value: '0, err: idle_err, last: 1'b1};
    res1   = res0;
    push_n = 2'd0;
    if (input_ended) begin
      res0   = '{kind: KIND_END, value: '0, err: ERR_NONE, last: 1'b1};
      push_n = 2'd1;
    end else if (pass_emit) begin
      res0 = '{kind: pass_kind, value: pass_value, err: pass_err, last: 1'b1};
      if (use_idle && idle_emit) begin
        res0.last = 1'b0;
        push_n    = 2'd2;
      end else begin
        push_n = 2'd1;
      end
    end else if (use_idle && idle_emit) begin
      push_n = 2'd1;
    end
  end

  // Counters, accumulator and word buffer.
  always_comb begin
    name_length_next   = name_length;
    number_accum_next  = number_accum;
    ident_count_next   = ident_count;
    string_count_next  = string_count;
    compare_first_next = compare_first;
    input_ended_next   = input_ended;
    name_wr            = 1'b0;
    name_wr_idx        = name_length[NAME_IDX_W-1:0];
    if (!input_ended) begin
      case (mode)
        MODE_WORD: begin
          if (!op && is_alnum) begin
            name_wr = (name_length < NAME_KEEP);
            if (name_length <= NAME_KEEP) begin
              name_length_next = name_length + 1'b1;
            end
          end else if (word_kind == KIND_ID) begin
            ident_count_next = ident_count + 1'b1;
          end
        end
        MODE_NUM: begin
          if (!op && is_digit) begin
            number_accum_next = num_step;
          end
        end
        MODE_CMT, MODE_CMT_STAR, MODE_BANG: begin
          if (op) begin
            input_ended_next = 1'b1;
          end
        end
        MODE_STR: begin
          if (op) begin
            input_ended_next = 1'b1;
          end else if (ch == CH_QUOTE) begin
            string_count_next = string_count + 1'b1;
          end
        end
        default: begin
          input_ended_next = input_ended;
        end
      endcase
      if (use_idle) begin
        if (idle_ended) begin
          input_ended_next = 1'b1;
        end
        if (idle_mode == MODE_WORD) begin
          name_wr          = 1'b1;
          name_wr_idx      = '0;
          name_length_next = NAME_LEN_W'(1);
        end
        if (idle_mode == MODE_NUM) begin
          number_accum_next = 31'(digit);
        end
        if (idle_mode == MODE_CMP) begin
          compare_first_next = idle_cmp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      name_length   <= '0;
      number_accum  <= '0;
      ident_count   <= '0;
      string_count  <= '0;
      compare_first <= CMP_EQ;
      input_ended   <= 1'b0;
    end else if (accept) begin
      mode          <= mode_next;
      name_length   <= name_length_next;
      number_accum  <= number_accum_next;
      ident_count   <= ident_count_next;
      string_count  <= string_count_next;
      compare_first <= compare_first_next;
      input_ended   <= input_ended_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && name_wr) begin
      name_chars[name_wr_idx] <= ch;
    end
  end

  // Result queue: up to two tokens written per request, one read per cycle while out_stall is low.
  always_ff @(posedge clk) begin
    if (accept && push_n != 2'd0) begin
      fifo[tail] <= res0;
    end
    if (accept && push_n == 2'd2) begin
      fifo[tail + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (accept) begin
        tail <= tail + push_n;
      end
      if (pop) begin
        head <= head + 2'd1;
      end
      count <= count + (accept ? 3'(push_n) : 3'd0) - 3'(pop);
    end
  end

  assign out_valid   = (count != 3'd0);
  assign in_stall    = (count > 3'd2);
  assign token_kind  = fifo[head].kind;
  assign token_value = fifo[head].value;
  assign error_code  = fifo[head].err;
  assign last        = fifo[head].last;

  `SCT_ASSERT_HOLDS(a_queue_bound, count <= 3'd4, "result queue overfilled")
  `SCT_ASSERT_NEXT(a_end_sticks, input_ended, input_ended, "end flag cleared without reset")
  `SCT_ASSERT_IMPLIES(a_pair_rescan, accept && push_n == 2'd2, mode != MODE_IDLE, "pair from idle")
  `SCT_ASSERT_IMPLIES(a_pair_queued, out_valid && !fifo[head].last, count >= 3'd2, "pair split")

endmodule
